// ----- rtl/pnfsa_pkg.sv -----
// Shared types and constants for the partitioned next-fit slot allocator.
// No dependencies; used by pnfsa_find and the top level.
`default_nettype none

package pnfsa_pkg;

    // Bitmap row geometry: one row holds the used bits of 64 slots.
    localparam int WORD_W     = 64;
    localparam int WORD_SEL_W = 6;

    // Default table geometry.
    localparam int TOTAL_SLOTS_DEF = 2048;
    localparam int LOW_SLOTS_DEF   = 1024;

    // Width of the slot index fields on the ports.
    localparam int SLOT_W = 11;

    // Request opcodes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REL      = 2'd2;
    localparam logic [1:0] ST_REL_FREE = 2'd3;

    // Result of searching one bitmap row for a free slot.
    typedef struct packed {
        logic                  found;
        logic [WORD_SEL_W-1:0] pos;
    } find_res_t;

endpackage

`default_nettype wire

// ----- rtl/pnfsa_find.sv -----
// Shared search unit: finds the lowest free slot of one bitmap row that
// lies inside a window [win_lo, win_hi). Depends on pnfsa_pkg.
`default_nettype none

module pnfsa_find #(
    parameter int ROW_W = 5
) (
    input  wire logic [pnfsa_pkg::WORD_W-1:0]             word,
    input  wire logic [ROW_W-1:0]                         row,
    input  wire logic [ROW_W+pnfsa_pkg::WORD_SEL_W:0]     win_lo,
    input  wire logic [ROW_W+pnfsa_pkg::WORD_SEL_W:0]     win_hi,
    output pnfsa_pkg::find_res_t                          res
);

    localparam int WW  = pnfsa_pkg::WORD_W;
    localparam int WS  = pnfsa_pkg::WORD_SEL_W;
    localparam int BW  = ROW_W + WS + 1;
    localparam int RW1 = ROW_W + 1;

    logic [RW1-1:0] row_x;
    logic [WW-1:0]  lo_mask;
    logic [WW-1:0]  hi_mask;
    logic [WW-1:0]  cand;

    assign row_x = RW1'(row);

    // Only the rows that hold a window edge are trimmed; rows in between
    // are searched in full.
    assign lo_mask = (row_x == win_lo[BW-1:WS]) ? ({WW{1'b1}} << win_lo[WS-1:0])
                                                : {WW{1'b1}};
    assign hi_mask = (row_x == win_hi[BW-1:WS]) ? ((WW'(1) << win_hi[WS-1:0]) - WW'(1))
                                                : {WW{1'b1}};
    assign cand    = ~word & lo_mask & hi_mask;

    always_comb
    begin
        res.found = |cand;
        res.pos   = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                res.pos = WS'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/partitioned_next_fit_slot_allocator.sv -----
// Top level of the partitioned next-fit slot allocator: sequencer, bitmap
// memory, hints and response register. Depends on pnfsa_pkg and pnfsa_find.
`default_nettype none

// The allocator keeps one used bit per slot in a memory of 64-bit rows and
// serves one request at a time; req_ready is high only while it is idle.
// After reset it runs a clearing pass over every bitmap row (32 rows for the
// default table) before it takes its first request. An allocation reads one
// bitmap row per cycle and hands it to a single masked find-first unit,
// wrapping around to the range base when nothing is free from the start slot
// to the range end. A release reads the row of its slot and clears the bit
// if it was set. The response sits in an output register, so the next
// request can be taken while a response beat is still waiting for rsp_ready.
module partitioned_next_fit_slot_allocator #(
    parameter int TOTAL_SLOTS = pnfsa_pkg::TOTAL_SLOTS_DEF,
    parameter int LOW_SLOTS   = pnfsa_pkg::LOW_SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic                         opcode,
    input  wire logic                         low_kind,
    input  wire logic [pnfsa_pkg::SLOT_W-1:0] release_slot,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic [1:0]                        status,
    output logic [pnfsa_pkg::SLOT_W-1:0]      slot
);

    localparam int WW       = pnfsa_pkg::WORD_W;
    localparam int WS       = pnfsa_pkg::WORD_SEL_W;
    localparam int SW       = pnfsa_pkg::SLOT_W;
    localparam int ROWS     = (TOTAL_SLOTS + WW - 1) / WW;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RW1      = ROW_W + 1;
    localparam int BW       = ROW_W + WS + 1;
    localparam int IDX_W    = $clog2(TOTAL_SLOTS);
    localparam int LOW_END  = (LOW_SLOTS < TOTAL_SLOTS) ? LOW_SLOTS : TOTAL_SLOTS;
    localparam int HIGH_RST = (LOW_SLOTS < TOTAL_SLOTS) ? LOW_SLOTS : 0;

    localparam logic [BW-1:0] LOW_END_B = BW'(LOW_END);
    localparam logic [BW-1:0] TOTAL_B   = BW'(TOTAL_SLOTS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_REL   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic             server_mode_reg, server_mode_next;
    logic [IDX_W-1:0] low_hint_reg, low_hint_next;
    logic [IDX_W-1:0] high_hint_reg, high_hint_next;
    logic [RW1-1:0]   row_reg, row_next;
    logic             phase_reg, phase_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic             op_reg, op_next;
    logic             low_kind_reg, low_kind_next;
    logic [SW-1:0]    rel_reg, rel_next;
    logic             use_low_reg, use_low_next;
    logic [BW-1:0]    lo_reg, lo_next;
    logic [BW-1:0]    hi_reg, hi_next;
    logic [BW-1:0]    s_reg, s_next;
    logic [BW-1:0]    win_lo_reg, win_lo_next;
    logic [BW-1:0]    win_hi_reg, win_hi_next;
    logic [RW1-1:0]   last_row_reg, last_row_next;
    logic [ROW_W-1:0] chk_row_reg, chk_row_next;
    logic [BW-1:0]    found_reg, found_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [SW-1:0]    res_slot_reg, res_slot_next;
    logic [1:0]       rsp_status_reg, rsp_status_next;
    logic [SW-1:0]    rsp_slot_reg, rsp_slot_next;
    logic [WW-1:0]    rd_word_reg;

    // Bitmap memory
    logic [WW-1:0]    bitmap_mem [ROWS];
    logic             mem_we;
    logic [ROW_W-1:0] mem_wa;
    logic [WW-1:0]    mem_wd;
    logic [ROW_W-1:0] mem_ra;

    // Request decode
    logic             use_low_c;
    logic [BW-1:0]    lo_c;
    logic [BW-1:0]    hi_c;
    logic [BW-1:0]    hint_c;
    logic [BW-1:0]    start_c;
    logic [BW-1:0]    hi_m1_c;
    logic [BW-1:0]    s_m1_c;
    logic [BW-1:0]    hint_inc_c;
    logic [BW-1:0]    hint_new_c;
    logic [BW-1:0]    rel_pos_c;
    logic             rel_in_c;
    logic             rel_bit_c;
    logic             issue_done_c;

    pnfsa_pkg::find_res_t fres;

    pnfsa_find #(
        .ROW_W (ROW_W)
    ) u_find (
        .word   (rd_word_reg),
        .row    (chk_row_reg),
        .win_lo (win_lo_reg),
        .win_hi (win_hi_reg),
        .res    (fres)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign slot      = rsp_slot_reg;

    assign use_low_c  = server_mode_reg & low_kind_reg;
    assign lo_c       = (server_mode_reg && !low_kind_reg) ? LOW_END_B : '0;
    assign hi_c       = use_low_c ? LOW_END_B : TOTAL_B;
    assign hint_c     = use_low_c ? BW'(low_hint_reg) : BW'(high_hint_reg);
    // A hint left outside its range by a mode change restarts at the range base.
    assign start_c    = ((hint_c < lo_c) || (hint_c >= hi_c)) ? lo_c : hint_c;
    assign hi_m1_c    = hi_c - BW'(1);
    assign s_m1_c     = s_reg - BW'(1);
    assign hint_inc_c = found_reg + BW'(1);
    assign hint_new_c = (hint_inc_c >= hi_reg) ? lo_reg : hint_inc_c;
    assign rel_pos_c  = BW'(rel_reg);
    assign rel_in_c   = (32'(rel_reg) < 32'(TOTAL_SLOTS));
    assign rel_bit_c  = rd_word_reg[rel_pos_c[WS-1:0]];
    assign issue_done_c = (row_reg > last_row_reg);

    always_comb
    begin
        state_next       = state_reg;
        server_mode_next = cfg_wr_en ? cfg_wr_data : server_mode_reg;
        low_hint_next    = low_hint_reg;
        high_hint_next   = high_hint_reg;
        row_next         = row_reg;
        phase_next       = phase_reg;
        chk_valid_next   = 1'b0;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        op_next          = op_reg;
        low_kind_next    = low_kind_reg;
        rel_next         = rel_reg;
        use_low_next     = use_low_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        s_next           = s_reg;
        win_lo_next      = win_lo_reg;
        win_hi_next      = win_hi_reg;
        last_row_next    = last_row_reg;
        chk_row_next     = row_reg[ROW_W-1:0];
        found_next       = found_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_slot_next    = rsp_slot_reg;
        mem_we           = 1'b0;
        mem_wa           = chk_row_reg;
        mem_wd           = rd_word_reg;
        mem_ra           = row_reg[ROW_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = row_reg[ROW_W-1:0];
                mem_wd = '0;
                if (row_reg == RW1'(ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + RW1'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = opcode;
                    low_kind_next = low_kind;
                    rel_next      = release_slot;
                    state_next    = S_SETUP;
                end
            end

            S_SETUP:
            begin
                use_low_next = use_low_c;
                lo_next      = lo_c;
                hi_next      = hi_c;
                s_next       = start_c;
                if (op_reg == pnfsa_pkg::OP_RELEASE)
                begin
                    res_slot_next = rel_reg;
                    if (rel_in_c)
                    begin
                        mem_ra     = rel_pos_c[WS +: ROW_W];
                        state_next = S_REL;
                    end
                    else
                    begin
                        res_status_next = pnfsa_pkg::ST_REL_FREE;
                        state_next      = S_RESP;
                    end
                end
                else if (hi_c <= lo_c)
                begin
                    res_status_next = pnfsa_pkg::ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    // First pass: from the start slot up to the range end.
                    win_lo_next   = start_c;
                    win_hi_next   = hi_c;
                    row_next      = start_c[BW-1:WS];
                    last_row_next = hi_m1_c[BW-1:WS];
                    phase_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Reads are issued one row ahead of the row being checked.
                if (!issue_done_c)
                begin
                    chk_valid_next = 1'b1;
                    row_next       = row_reg + RW1'(1);
                end
                if (chk_valid_reg && fres.found)
                begin
                    mem_we         = 1'b1;
                    mem_wa         = chk_row_reg;
                    mem_wd         = rd_word_reg | (WW'(1) << fres.pos);
                    found_next     = BW'({chk_row_reg, fres.pos});
                    chk_valid_next = 1'b0;
                    state_next     = S_MARK;
                end
                else if (!chk_valid_reg && issue_done_c)
                begin
                    if (!phase_reg && (s_reg != lo_reg))
                    begin
                        // Wrap around: from the range base up to the start slot.
                        phase_next    = 1'b1;
                        win_lo_next   = lo_reg;
                        win_hi_next   = s_reg;
                        row_next      = lo_reg[BW-1:WS];
                        last_row_next = s_m1_c[BW-1:WS];
                    end
                    else
                    begin
                        res_status_next = pnfsa_pkg::ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_RESP;
                    end
                end
            end

            S_MARK:
            begin
                if (use_low_reg)
                begin
                    low_hint_next = IDX_W'(hint_new_c);
                end
                else
                begin
                    high_hint_next = IDX_W'(hint_new_c);
                end
                res_status_next = pnfsa_pkg::ST_ALLOC;
                res_slot_next   = SW'(found_reg);
                state_next      = S_RESP;
            end

            S_REL:
            begin
                mem_wa = rel_pos_c[WS +: ROW_W];
                if (rel_bit_c)
                begin
                    mem_we          = 1'b1;
                    mem_wd          = rd_word_reg & ~(WW'(1) << rel_pos_c[WS-1:0]);
                    res_status_next = pnfsa_pkg::ST_REL;
                end
                else
                begin
                    res_status_next = pnfsa_pkg::ST_REL_FREE;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            server_mode_reg <= 1'b0;
            low_hint_reg    <= '0;
            high_hint_reg   <= IDX_W'(HIGH_RST);
            row_reg         <= '0;
            phase_reg       <= 1'b0;
            chk_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            server_mode_reg <= server_mode_next;
            low_hint_reg    <= low_hint_next;
            high_hint_reg   <= high_hint_next;
            row_reg         <= row_next;
            phase_reg       <= phase_next;
            chk_valid_reg   <= chk_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        low_kind_reg   <= low_kind_next;
        rel_reg        <= rel_next;
        use_low_reg    <= use_low_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        s_reg          <= s_next;
        win_lo_reg     <= win_lo_next;
        win_hi_reg     <= win_hi_next;
        last_row_reg   <= last_row_next;
        chk_row_reg    <= chk_row_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_wa] <= mem_wd;
        end
        rd_word_reg <= bitmap_mem[mem_ra];
    end

`ifndef ASSERT_OFF
    // The slot that was just marked lies inside the searched range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> ((found_reg >= lo_reg) && (found_reg < hi_reg)))
        else $error("allocated slot outside its range");

    // Both hints always stay below the end of the slot range they serve.
    assert property (@(posedge clk) disable iff (!rst_n)
        (BW'(low_hint_reg) < LOW_END_B) && (BW'(high_hint_reg) < TOTAL_B))
        else $error("rotating hint out of range");

    // A row is only checked after a read was issued for it during the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> ($past(state_reg) == S_SCAN))
        else $error("row checked without a scan read");

    // A finished result waits while the previous response beat is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && rsp_valid_reg && !rsp_ready) |=> (state_reg == S_RESP))
        else $error("response overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- tb/partitioned_next_fit_slot_allocator_test.sv -----
// Self-checking testbench for the partitioned next-fit slot allocator: a queue-fed
// driver, a response monitor and a behavioral predictor of bitmap and hints.
// Depends on pnfsa_pkg and the partitioned_next_fit_slot_allocator RTL.
module partitioned_next_fit_slot_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = pnfsa_pkg::TOTAL_SLOTS_DEF;
    localparam int LOW_COUNT   = pnfsa_pkg::LOW_SLOTS_DEF;
    localparam int LOW_END     = (LOW_COUNT < NUM_SLOTS) ? LOW_COUNT : NUM_SLOTS;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic                         op;
        logic                         kind;
        logic [pnfsa_pkg::SLOT_W-1:0] rel;
        bit                           aim_used;
    } req_t;

    typedef struct {
        logic [1:0]                   status;
        logic [pnfsa_pkg::SLOT_W-1:0] slot;
    } rsp_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic                         cfg_wr_data = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_ready;
    logic                         opcode = pnfsa_pkg::OP_ALLOC;
    logic                         low_kind = 1'b0;
    logic [pnfsa_pkg::SLOT_W-1:0] release_slot = '0;
    logic                         rsp_valid;
    logic                         rsp_ready = 1'b0;
    logic [1:0]                   status;
    logic [pnfsa_pkg::SLOT_W-1:0] slot;

    req_t request_queue[$];
    rsp_t due_responses[$];

    // Predictor state.
    bit used_bits [NUM_SLOTS];
    int low_hint = 0;
    int high_hint = LOW_COUNT;
    bit split_mode = 1'b0;

    int  fail_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  sender_idles = 1'b1;
    bit  rsp_idles = 1'b1;

    partitioned_next_fit_slot_allocator #(
        .TOTAL_SLOTS(NUM_SLOTS),
        .LOW_SLOTS  (LOW_COUNT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .opcode      (opcode),
        .low_kind    (low_kind),
        .release_slot(release_slot),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .slot        (slot)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Next-fit scan with wraparound over [lo, hi); -1 when the range is full.
    function automatic int first_free_from(input int lo, input int hi, input int hint);
        int idx;
        int n;
        if (hi <= lo)
            return -1;
        idx = (hint < lo || hint >= hi) ? lo : hint;
        for (n = 0; n < hi - lo; n++)
        begin
            if (!used_bits[idx])
                return idx;
            idx = (idx + 1 >= hi) ? lo : idx + 1;
        end
        return -1;
    endfunction

    task automatic compute_response(input logic op, input logic kind,
                                    input logic [pnfsa_pkg::SLOT_W-1:0] rel,
                                    output rsp_t res);
        int lo;
        int hi;
        int hint;
        int pick;
        int nxt;
        res.status = pnfsa_pkg::ST_FULL;
        res.slot = '0;
        if (op == pnfsa_pkg::OP_RELEASE)
        begin
            res.slot = rel;
            if (int'(rel) < NUM_SLOTS && used_bits[rel])
            begin
                used_bits[rel] = 1'b0;
                res.status = pnfsa_pkg::ST_REL;
            end
            else
                res.status = pnfsa_pkg::ST_REL_FREE;
        end
        else
        begin
            if (split_mode && kind)
            begin
                lo = 0;
                hi = LOW_END;
                hint = low_hint;
            end
            else if (split_mode)
            begin
                lo = LOW_END;
                hi = NUM_SLOTS;
                hint = high_hint;
            end
            else
            begin
                lo = 0;
                hi = NUM_SLOTS;
                hint = high_hint;
            end
            pick = first_free_from(lo, hi, hint);
            if (pick >= 0)
            begin
                used_bits[pick] = 1'b1;
                res.status = pnfsa_pkg::ST_ALLOC;
                res.slot = pick[pnfsa_pkg::SLOT_W-1:0];
                nxt = (pick + 1 >= hi) ? lo : pick + 1;
                if (split_mode && kind)
                    low_hint = nxt;
                else
                    high_hint = nxt;
            end
        end
    endtask

    // Driver: predicts each accepted request beat and presents the next one.
    always @(posedge clk)
    begin : driver
        req_t nxt;
        rsp_t want;
        int   start;
        int   k;
        int   idx;
        if (cfg_wr_en)
            split_mode = cfg_wr_data;
        if (req_valid && req_ready)
        begin
            compute_response(opcode, low_kind, release_slot, want);
            due_responses.push_back(want);
        end
        if (!req_valid || req_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                nxt = request_queue.pop_front();
                // Targeted releases pick a slot that is in use right now, if there is one.
                if (nxt.op == pnfsa_pkg::OP_RELEASE && nxt.aim_used)
                begin
                    start = $urandom_range(0, NUM_SLOTS - 1);
                    for (k = 0; k < NUM_SLOTS; k++)
                    begin
                        idx = (start + k) % NUM_SLOTS;
                        if (used_bits[idx])
                        begin
                            nxt.rel = idx[pnfsa_pkg::SLOT_W-1:0];
                            break;
                        end
                    end
                end
                req_valid <= 1'b1;
                opcode <= nxt.op;
                low_kind <= nxt.kind;
                release_slot <= nxt.rel;
                if (sender_idles && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Monitor: checks each response beat against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (due_responses.size() == 0)
            begin
                $error("response beat with nothing expected: status %0d slot %0d",
                       status, slot);
                fail_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (rsp_idles && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_req(input logic op, input logic kind, input int rel, input bit aim);
        req_t r;
        r.op = op;
        r.kind = kind;
        r.rel = rel[pnfsa_pkg::SLOT_W-1:0];
        r.aim_used = aim;
        request_queue.push_back(r);
    endtask

    // Holds the sender until every queued beat is taken and answered.
    task automatic settle();
        while (request_queue.size() != 0 || req_valid || due_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic value);
        settle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 55)
                push_req(pnfsa_pkg::OP_ALLOC, 1'($urandom_range(0, 1)),
                         $urandom_range(0, NUM_SLOTS - 1), 1'b0);
            else
                push_req(pnfsa_pkg::OP_RELEASE, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 2047), $urandom_range(0, 3) != 0);
        end
    endtask

    initial
    begin : stimulus
        int p;
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: basic allocation order, double release, edge slots,
        // mode switch with the low hint and the high hint both in play.
        write_mode(1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 2047, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 1025, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b1, 1025, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 2047, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 0, 1'b0);
        write_mode(1'b1);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 0, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 0, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 1, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b1, 2047, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 1024, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 11'h555, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b1, 11'h2aa, 1'b0);
        write_mode(1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b1, 0, 1'b0);
        push_req(pnfsa_pkg::OP_ALLOC, 1'b0, 0, 1'b0);
        push_req(pnfsa_pkg::OP_RELEASE, 1'b0, 0, 1'b1);

        // Random phases, each one started from an idle block.
        for (p = 0; p < 6; p++)
        begin
            write_mode(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            sender_idles = (p != 2);
            rsp_idles = (p != 2) && (p != 4);
            push_random(100);
        end

        // Split mode: alternating kinds, then for the low range and then the high
        // range, releases spread over it followed by allocations skewed toward it.
        write_mode(1'b1);
        sender_idles = 1'b1;
        rsp_idles = 1'b1;
        for (i = 0; i < 8; i++)
            push_req(pnfsa_pkg::OP_ALLOC, 1'(i % 2), 0, 1'b0);
        for (i = 0; i < 20; i++)
            push_req(pnfsa_pkg::OP_RELEASE, 1'b0, $urandom_range(0, LOW_END - 1), 1'b0);
        for (i = 0; i < 25; i++)
            push_req(pnfsa_pkg::OP_ALLOC, $urandom_range(0, 3) != 0, 0, 1'b0);
        for (i = 0; i < 20; i++)
            push_req(pnfsa_pkg::OP_RELEASE, 1'b1,
                     $urandom_range(LOW_END, NUM_SLOTS - 1), 1'b0);
        for (i = 0; i < 25; i++)
            push_req(pnfsa_pkg::OP_ALLOC, $urandom_range(0, 3) == 0, 0, 1'b0);

        // Closing stretch at full rate.
        write_mode(1'($urandom_range(0, 1)));
        sender_idles = 1'b0;
        rsp_idles = 1'b0;
        push_random(100);

        settle();
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
